// File: design/sorted_list_table_engine_unit_defines.svh
// ----------------------------------------------------------------------------
// sorted list table engine assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_ENGINE_UNIT_DEFINES_SVH
`define SORTED_LIST_TABLE_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLTE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slte assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SLTE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slte assertion failed");

`endif

// File: design/slte_pkg.sv
// ----------------------------------------------------------------------------
// slte_pkg
// widths, codes and the token that walks the cell chain
// ----------------------------------------------------------------------------
`default_nettype none

package slte_pkg;

	localparam int CAPACITY = 64;
	localparam int VALUE_W  = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OP_W     = 3;
	localparam int ST_W     = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INS_SORTED = 3'd0,
		OP_INS_HEAD   = 3'd1,
		OP_REMOVE     = 3'd2,
		OP_SEARCH     = 3'd3,
		OP_READ       = 3'd4,
		OP_CLEAR      = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_WALK = 1'b1
	} state_t;

	// request token handed from cell to cell
	typedef struct packed {
		logic               active;
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] value;
		logic [CNT_W-1:0]   position;
		logic [IDX_W-1:0]   idx;
		logic [CNT_W-1:0]   count;
		logic               done;
		logic [VALUE_W-1:0] carry;
		logic [VALUE_W-1:0] fval;
		logic [CNT_W-1:0]   fpos;
	} tok_t;

endpackage

`default_nettype wire

// File: design/slte_cell.sv
// ----------------------------------------------------------------------------
// slte_cell
// one list slot: compares, inserts, shifts and matches as the token passes
// ----------------------------------------------------------------------------
`default_nettype none

module slte_cell
	import slte_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire tok_t               tok_in,
	output tok_t                    tok_out,
	input  wire logic [VALUE_W-1:0] right_entry,
	output logic [VALUE_W-1:0]      entry
);

	tok_t               tok_q;
	tok_t               tok_d;
	logic [VALUE_W-1:0] entry_q;
	logic [VALUE_W-1:0] entry_d;
	logic [CNT_W-1:0]   idx_ext;
	logic [CNT_W-1:0]   my_pos;
	logic               slot_valid;
	logic               has_room;
	logic               is_insert;
	logic               hit;

	always_comb begin
		idx_ext    = {{(CNT_W-IDX_W){1'b0}}, tok_in.idx};
		my_pos     = idx_ext + CNT_W'(1);
		slot_valid = idx_ext < tok_in.count;
		has_room   = tok_in.count < CNT_W'(CAPACITY);
		is_insert  = (tok_in.op == OP_INS_SORTED) || (tok_in.op == OP_INS_HEAD);
		hit        = 1'b0;
		case (tok_in.op)
			OP_INS_SORTED: hit = has_room &&
				(!slot_valid || !($signed(entry_q) < $signed(tok_in.value)));
			OP_INS_HEAD:   hit = has_room;
			OP_REMOVE,
			OP_SEARCH:     hit = slot_valid && (entry_q == tok_in.value);
			OP_READ:       hit = slot_valid && (my_pos == tok_in.position);
			default:       hit = 1'b0;
		endcase

		tok_d     = tok_in;
		tok_d.idx = tok_in.idx + IDX_W'(1);
		entry_d   = entry_q;

		// removal closes the gap one slot per cycle behind the token while en is high
		if (tok_q.active && tok_q.done && (tok_q.op == OP_REMOVE)) begin
			entry_d = right_entry;
		end

		if (tok_in.active && !tok_in.done && hit) begin
			tok_d.done = 1'b1;
			tok_d.fpos = my_pos;
			if (is_insert) begin
				tok_d.carry = entry_q;
				entry_d     = tok_in.value;
			end
			if ((tok_in.op == OP_SEARCH) || (tok_in.op == OP_READ)) begin
				tok_d.fval = entry_q;
			end
		end else if (tok_in.active && tok_in.done && is_insert) begin
			// shift the displaced entry one slot to the right
			tok_d.carry = entry_q;
			entry_d     = tok_in.carry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.active <= 1'b0;
		end else if (en) begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			entry_q <= entry_d;
		end
	end

	assign tok_out = tok_q;
	assign entry   = entry_q;

endmodule

`default_nettype wire

// File: design/sorted_list_table_engine_unit.sv
// flow: one request in flight at a time; the request token
//   walks the row of list cells one cell per cycle, and the next beat is taken
//   once the result sits in the output register
// reset: clears the entry count, the tokens and the output valid; list slots
//   are not reset, only slots below the count are ever read
// ----------------------------------------------------------------------------
// sorted_list_table_engine_unit
// bounded ordered list of signed values built as a chain of compare cells
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_table_engine_unit
	import slte_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [OP_W-1:0]           operation,
	input  wire logic signed [VALUE_W-1:0] value,
	input  wire logic [CNT_W-1:0]          position,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [ST_W-1:0]                status,
	output logic signed [VALUE_W-1:0]      found_value,
	output logic [CNT_W-1:0]               found_position,
	output logic [CNT_W-1:0]               entry_count,
	output logic                           is_empty
);

	state_t             state_q;
	state_t             state_d;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic               en;
	logic               in_acc;
	logic               tail_take;
	tok_t               chain [CAPACITY+1];
	logic [VALUE_W-1:0] ent [CAPACITY+1];
	tok_t               tail;
	logic [ST_W-1:0]    stat_d;

	logic               out_valid_q;
	logic [ST_W-1:0]    status_q;
	logic [VALUE_W-1:0] fval_q;
	logic [CNT_W-1:0]   fpos_q;
	logic [CNT_W-1:0]   cnt_out_q;
	logic               empty_q;

	assign tail      = chain[CAPACITY];
	// freeze the row while a finished result cannot leave
	assign en        = !(tail.active && out_valid_q && !out_ready);
	assign in_acc    = in_valid && in_ready;
	assign tail_take = tail.active && en;

	always_comb begin
		chain[0]          = '0;
		chain[0].active   = in_acc;
		chain[0].op       = operation;
		chain[0].value    = value;
		chain[0].position = position;
		chain[0].count    = count_q;
	end

	assign ent[CAPACITY] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		slte_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.tok_in     (chain[i]),
			.tok_out    (chain[i+1]),
			.right_entry(ent[i+1]),
			.entry      (ent[i])
		);
	end

	// result and new count from the token leaving the last cell
	always_comb begin
		stat_d  = STAT_OK;
		count_d = tail.count;
		case (tail.op)
			OP_INS_SORTED,
			OP_INS_HEAD: begin
				if (tail.done) begin
					count_d = tail.count + CNT_W'(1);
				end else begin
					stat_d = STAT_FULL;
				end
			end
			OP_REMOVE,
			OP_SEARCH: begin
				if (tail.count == '0) begin
					stat_d = STAT_EMPTY;
				end else if (!tail.done) begin
					stat_d = STAT_NOT_FOUND;
				end else if (tail.op == OP_REMOVE) begin
					count_d = tail.count - CNT_W'(1);
				end
			end
			OP_READ: begin
				if (!tail.done) begin
					stat_d = STAT_NOT_FOUND;
				end
			end
			OP_CLEAR: count_d = '0;
			default:  count_d = tail.count;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_acc) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (tail_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (tail_take) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail_take) begin
			status_q  <= stat_d;
			fval_q    <= tail.fval;
			fpos_q    <= tail.fpos;
			cnt_out_q <= count_d;
			empty_q   <= (count_d == '0);
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found_value    = $signed(fval_q);
	assign found_position = fpos_q;
	assign entry_count    = cnt_out_q;
	assign is_empty       = empty_q;

endmodule

`default_nettype wire

// File: design/slte_checker.sv
// ----------------------------------------------------------------------------
// slte_checker
// port-level checks on the sorted list table engine
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_list_table_engine_unit_defines.svh"

module slte_checker
	import slte_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [ST_W-1:0]           status,
	input wire logic [CNT_W-1:0]          entry_count,
	input wire logic                      is_empty
);

	// a result beat waits until taken
	`SLTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// one request in flight at a time
	`SLTE_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	// empty flag follows the reported count
	`SLTE_ASSERT_NOW(a_empty_flag, out_valid, is_empty == (entry_count == '0))
	// a dropped insert only happens on a full list
	`SLTE_ASSERT_NOW(a_full_count, out_valid && (status == STAT_FULL),
		entry_count == CNT_W'(CAPACITY))

endmodule

bind sorted_list_table_engine_unit slte_checker u_slte_checker (.*);

`default_nettype wire
